/* rtl/mexp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg: shared types, constants and microprogram for modular_exponentiation
// Holds the field widths, the control word layout and the program ROM.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int EXP_W         = 31;   // width of base, exponent, modulus
    localparam int WORD_BITS_DEF = 32;   // exponent bits scanned by default

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        OP_FETCH,   // take a request, load working registers
        OP_MUL,     // run one modular multiply
        OP_SKIP,    // jump to target when the current exponent bit is clear
        OP_LOOP,    // advance to next exponent bit, jump to target unless last
        OP_CLEAR,   // force the accumulator to zero
        OP_EMIT     // hand the accumulator to the output register
    } t_op;

    typedef enum logic [1:0] {
        SRC_ONE,
        SRC_ACC,
        SRC_BASE
    } t_src;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_ACC,
        DST_BASE
    } t_dst;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_FETCH  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_REDUCE = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SQUARE = PC_W'(2);
    localparam logic [PC_W-1:0] PC_TEST   = PC_W'(3);
    localparam logic [PC_W-1:0] PC_MULB   = PC_W'(4);
    localparam logic [PC_W-1:0] PC_NEXT   = PC_W'(5);
    localparam logic [PC_W-1:0] PC_OUT    = PC_W'(6);
    localparam logic [PC_W-1:0] PC_ZERO   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_ZOUT   = PC_W'(8);
    localparam logic [PC_W-1:0] PC_LAST   = PC_ZOUT;

    typedef struct packed {
        t_op             op;
        t_src            x_sel;
        t_src            y_sel;
        t_dst            dst;
        logic [PC_W-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic in_ready;
        logic in_fire;
        logic mul_start;
        logic mul_wr;
        t_src x_sel;
        t_src y_sel;
        t_dst dst;
        logic loop_step;
        logic clear_acc;
        logic out_load;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic mul_done;
        logic ebit;
        logic cnt_zero;
        logic mod_small;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        case (pc)
            PC_FETCH:  uw = '{op: OP_FETCH, x_sel: SRC_ONE, y_sel: SRC_ONE,
                              dst: DST_NONE, target: PC_ZERO};
            PC_REDUCE: uw = '{op: OP_MUL, x_sel: SRC_ONE, y_sel: SRC_BASE,
                              dst: DST_BASE, target: PC_FETCH};
            PC_SQUARE: uw = '{op: OP_MUL, x_sel: SRC_ACC, y_sel: SRC_ACC,
                              dst: DST_ACC, target: PC_FETCH};
            PC_TEST:   uw = '{op: OP_SKIP, x_sel: SRC_ONE, y_sel: SRC_ONE,
                              dst: DST_NONE, target: PC_NEXT};
            PC_MULB:   uw = '{op: OP_MUL, x_sel: SRC_ACC, y_sel: SRC_BASE,
                              dst: DST_ACC, target: PC_FETCH};
            PC_NEXT:   uw = '{op: OP_LOOP, x_sel: SRC_ONE, y_sel: SRC_ONE,
                              dst: DST_NONE, target: PC_SQUARE};
            PC_OUT:    uw = '{op: OP_EMIT, x_sel: SRC_ONE, y_sel: SRC_ONE,
                              dst: DST_NONE, target: PC_FETCH};
            PC_ZERO:   uw = '{op: OP_CLEAR, x_sel: SRC_ONE, y_sel: SRC_ONE,
                              dst: DST_NONE, target: PC_FETCH};
            PC_ZOUT:   uw = '{op: OP_EMIT, x_sel: SRC_ONE, y_sel: SRC_ONE,
                              dst: DST_NONE, target: PC_FETCH};
            default:   uw = '{op: OP_FETCH, x_sel: SRC_ONE, y_sel: SRC_ONE,
                              dst: DST_NONE, target: PC_FETCH};
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

/* rtl/mexp_mulmod.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_mulmod: iterative modular multiplier
// Interleaved shift-add reduction, one multiplier bit per cycle, MSB first.
// Result is x*y mod m when x < m.
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [EXP_W-1:0] i_x,
    input  wire logic [EXP_W-1:0] i_y,
    input  wire logic [EXP_W-1:0] i_mod,
    output logic                  o_done,
    output logic [EXP_W-1:0]      o_result
);

    localparam int CNT_W = $clog2(EXP_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [EXP_W-1:0] r_x;
    logic [EXP_W-1:0] r_y;
    logic [EXP_W-1:0] r_m;
    logic [EXP_W-1:0] r_acc;
    logic [EXP_W-1:0] n_acc;

    logic [EXP_W+1:0] sum;
    logic [EXP_W+1:0] m1;
    logic [EXP_W+1:0] m2;

    // 2r + x stays below 3m, so at most one of m or 2m comes off
    always_comb begin
        sum = {1'b0, r_acc, 1'b0} + (r_y[EXP_W-1] ? {2'b00, r_x} : '0);
        m1  = {2'b00, r_m};
        m2  = {1'b0, r_m, 1'b0};
        if (sum >= m2) begin
            n_acc = EXP_W'(sum - m2);
        end else if (sum >= m1) begin
            n_acc = EXP_W'(sum - m1);
        end else begin
            n_acc = EXP_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(EXP_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_mod;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[EXP_W-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_x < r_m)) |-> (r_acc < r_m))
        else $error("modular product not below modulus");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("multiply started while busy");

endmodule
`default_nettype wire

/* rtl/mexp_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_seq: microprogram sequencer
// Steps through the program ROM, evaluates jump conditions and issues
// datapath controls.
// ----------------------------------------------------------------------------
module mexp_seq
    import mexp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_started;
    t_uword          uw;
    t_ctrl           ctrl;

    always_comb begin
        uw         = ucode(r_pc);
        n_pc       = r_pc;
        ctrl       = '0;
        ctrl.x_sel = uw.x_sel;
        ctrl.y_sel = uw.y_sel;
        ctrl.dst   = uw.dst;
        case (uw.op)
            OP_FETCH: begin
                ctrl.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    ctrl.in_fire = 1'b1;
                    n_pc = i_stat.mod_small ? uw.target : r_pc + PC_W'(1);
                end
            end
            OP_MUL: begin
                ctrl.mul_start = !r_started;
                if (i_stat.mul_done) begin
                    ctrl.mul_wr = 1'b1;
                    n_pc = r_pc + PC_W'(1);
                end
            end
            OP_SKIP: begin
                n_pc = i_stat.ebit ? r_pc + PC_W'(1) : uw.target;
            end
            OP_LOOP: begin
                ctrl.loop_step = 1'b1;
                n_pc = i_stat.cnt_zero ? r_pc + PC_W'(1) : uw.target;
            end
            OP_CLEAR: begin
                ctrl.clear_acc = 1'b1;
                n_pc = r_pc + PC_W'(1);
            end
            OP_EMIT: begin
                if (i_stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    n_pc = uw.target;
                end
            end
            default: begin
                n_pc = PC_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_FETCH;
            r_started <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_stat.mul_done) begin
                r_started <= 1'b0;
            end else if (ctrl.mul_start) begin
                r_started <= 1'b1;
            end
        end
    end

    assign o_ctrl = ctrl;

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mul_done |-> (uw.op == OP_MUL))
        else $error("multiply finished outside a multiply step");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_LAST)
        else $error("step counter left the program");

endmodule
`default_nettype wire

/* rtl/modular_exponentiation.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus, one request at a time
//
// Channels: input requests carry i_base_value (i_in_valid / o_in_ready);
// results leave on o_power_residue (o_out_valid / i_out_ready). The exponent
// (index 0) and modulus (index 1) are written through i_cfg_valid,
// i_cfg_index, i_cfg_data; o_cfg_ready is always high and other indexes are
// dropped. Write configuration only while no request is in flight.
// Method: left-to-right square-and-multiply over WORD_BITS exponent bits on
// one bit-serial modular multiplier. A request first reduces the base, then
// for each bit squares the accumulator and, where the bit is set, multiplies
// by the base. At WORD_BITS = 32 only 31 exponent bits can be set; a modulus
// below 2 gives 0.
// The multiplier is the limiting unit; one request is worked on at a time.
// The result sits in an output register, so a new request is accepted while
// the receiver stalls; the next result waits until that register frees up.
// Reset: synchronous, active low; exponent returns to 1, modulus to 2, no
// result pending.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [EXP_W-1:0]     i_base_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [EXP_W-1:0]          o_power_residue,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [EXP_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(WORD_BITS);

    logic [EXP_W-1:0]     r_exponent;
    logic [EXP_W-1:0]     r_modulus;
    logic [EXP_W-1:0]     r_acc;
    logic [EXP_W-1:0]     r_base;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_ebits;
    logic                 r_out_valid;
    logic [EXP_W-1:0]     r_out_data;

    logic [WORD_BITS+EXP_W-1:0] exp_ext;
    logic [EXP_W-1:0]           mul_x;
    logic [EXP_W-1:0]           mul_y;
    logic [EXP_W-1:0]           mul_res;
    logic                       mul_done;
    t_ctrl                      ctrl;
    t_stat                      stat;

    function automatic logic [EXP_W-1:0] pick(input t_src sel,
                                              input logic [EXP_W-1:0] acc,
                                              input logic [EXP_W-1:0] base);
        logic [EXP_W-1:0] v;
        case (sel)
            SRC_ONE:  v = EXP_W'(1);
            SRC_ACC:  v = acc;
            SRC_BASE: v = base;
            default:  v = EXP_W'(1);
        endcase
        return v;
    endfunction

    assign exp_ext = {{WORD_BITS{1'b0}}, r_exponent};
    assign mul_x   = pick(ctrl.x_sel, r_acc, r_base);
    assign mul_y   = pick(ctrl.y_sel, r_acc, r_base);

    always_comb begin
        stat.in_valid  = i_in_valid;
        stat.mul_done  = mul_done;
        stat.ebit      = r_ebits[WORD_BITS-1];
        stat.cnt_zero  = (r_cnt == '0);
        stat.mod_small = (r_modulus[EXP_W-1:1] == '0);
        stat.out_free  = !r_out_valid || i_out_ready;
    end

    mexp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ctrl.mul_start),
        .i_x      (mul_x),
        .i_y      (mul_y),
        .i_mod    (r_modulus),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // configuration and output handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent  <= EXP_W'(1);
            r_modulus   <= EXP_W'(2);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_EXPONENT) begin
                    r_exponent <= i_cfg_data;
                end else if (i_cfg_index == CFG_MODULUS) begin
                    r_modulus <= i_cfg_data;
                end
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (ctrl.in_fire) begin
            r_base  <= i_base_value;
            r_acc   <= EXP_W'(1);
            r_cnt   <= CNT_W'(WORD_BITS - 1);
            r_ebits <= exp_ext[WORD_BITS-1:0];
        end else begin
            if (ctrl.mul_wr && ctrl.dst == DST_ACC) begin
                r_acc <= mul_res;
            end
            if (ctrl.mul_wr && ctrl.dst == DST_BASE) begin
                r_base <= mul_res;
            end
            if (ctrl.clear_acc) begin
                r_acc <= '0;
            end
            // advance to the next lower exponent bit
            if (ctrl.loop_step && !stat.cnt_zero) begin
                r_cnt   <= r_cnt - CNT_W'(1);
                r_ebits <= {r_ebits[WORD_BITS-2:0], 1'b0};
            end
        end
        if (ctrl.out_load) begin
            r_out_data <= r_acc;
        end
    end

    assign o_in_ready      = ctrl.in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_power_residue = r_out_data;
    assign o_cfg_ready     = 1'b1;

endmodule
`default_nettype wire

/* dv/modular_exponentiation_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_test: self-checking bench for modular_exponentiation
// Walks a directed table of key settings and bases, then random settings with
// random bases, under three idle patterns. Every result is checked in order
// against a listed value or a square-and-multiply predictor kept inside the bench.
// ----------------------------------------------------------------------------
module modular_exponentiation_test
    import mexp_pkg::*;
();

    localparam int STALL_LIMIT    = 20000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 2400;   // above the worst request latency
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int BASES_PER_SETTING  = 10;
    localparam int MAX_REPORTS    = 10;

    localparam logic [EXP_W-1:0] FIELD_MAX = {EXP_W{1'b1}};

    // indexes with no register behind them; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum bit {STEP_WRITE, STEP_BASE} t_step_kind;

    typedef struct {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [EXP_W-1:0]     value;
        bit                   typed;
        logic [EXP_W-1:0]     want;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [EXP_W-1:0]     i_base_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [EXP_W-1:0]     o_power_residue;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [EXP_W-1:0]     i_cfg_data = '0;

    modular_exponentiation u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_base_value    (i_base_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_power_residue (o_power_residue),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // key as the block should hold it
    logic [EXP_W-1:0] key_exponent = EXP_W'(1);
    logic [EXP_W-1:0] key_modulus  = EXP_W'(2);

    logic [EXP_W-1:0] residues_due[$];
    t_step            directed_steps[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_requests    = 0;
    int n_writes      = 0;
    int n_settings    = 0;
    int n_results     = 0;
    int n_failures    = 0;
    int quiet_cycles  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [EXP_W-1:0] power_residue_of(input logic [EXP_W-1:0] b,
                                                          input logic [EXP_W-1:0] e,
                                                          input logic [EXP_W-1:0] m);
        longint unsigned acc;
        longint unsigned red_base;
        longint unsigned mod_w;
        if (m == '0)
            return '0;
        mod_w    = longint'(m);
        red_base = longint'(b) % mod_w;
        acc      = 64'd1 % mod_w;
        for (int bit_i = WORD_BITS_DEF - 1; bit_i >= 0; bit_i--) begin
            acc = (acc * acc) % mod_w;
            if (bit_i < EXP_W && e[bit_i])
                acc = (acc * red_base) % mod_w;
        end
        return acc[EXP_W-1:0];
    endfunction

    function automatic t_step cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [EXP_W-1:0] value);
        t_step s;
        s = '{STEP_WRITE, idx, value, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step base_step(input logic [EXP_W-1:0] b);
        t_step s;
        s = '{STEP_BASE, CFG_EXPONENT, b, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step typed_step(input logic [EXP_W-1:0] b,
                                         input logic [EXP_W-1:0] want);
        t_step s;
        s = '{STEP_BASE, CFG_EXPONENT, b, 1'b1, want};
        return s;
    endfunction

    function automatic logic [EXP_W-1:0] pick_exponent();
        case ($urandom_range(5))
            0: return '0;
            1: return EXP_W'(1);
            2: return FIELD_MAX;
            3: return EXP_W'($urandom_range(2, 255));
            default: return EXP_W'($urandom);
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] pick_modulus();
        case ($urandom_range(7))
            0: return EXP_W'(2);
            1: return FIELD_MAX;
            2: return EXP_W'($urandom_range(3, 1000));
            3: return EXP_W'($urandom_range(0, 1));
            default: return EXP_W'($urandom);
        endcase
    endfunction

    function automatic logic [EXP_W-1:0] pick_base(input logic [EXP_W-1:0] m);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0: return (m != '0) ? m - EXP_W'(1) : '0;
            1: return (m != '0) ? EXP_W'(r % {1'b0, m}) : EXP_W'(r);
            2: return EXP_W'({1'b0, m} + (r % 16));  // at or just above the modulus
            3: return EXP_W'($urandom_range(0, 1));
            default: return EXP_W'(r);
        endcase
    endfunction

    task automatic log_failure(input string what, input logic [EXP_W-1:0] want,
                               input logic [EXP_W-1:0] got);
        n_failures++;
        if (n_failures <= MAX_REPORTS)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Drop any pending request, wait until the block is drained, then write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [EXP_W-1:0] value);
        i_in_valid <= 1'b0;
        while (residues_due.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_EXPONENT)
            key_exponent = value;
        else if (idx == CFG_MODULUS)
            key_modulus = value;
        n_writes++;
    endtask

    task automatic send_base(input logic [EXP_W-1:0] b, input bit typed,
                             input logic [EXP_W-1:0] want);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_base_value <= b;
        do @(posedge i_clk); while (!o_in_ready);
        residues_due.push_back(typed ? want
                                     : power_residue_of(b, key_exponent, key_modulus));
        n_requests++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        logic [EXP_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (residues_due.size() == 0) begin
                log_failure("result with no request pending", '0, o_power_residue);
            end else begin
                want = residues_due.pop_front();
                if (o_power_residue !== want)
                    log_failure("power_residue mismatch", want, o_power_residue);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("[%0t] no handshake for %0d cycles, %0d results pending",
                 $realtime, STALL_LIMIT, residues_due.size());
        $display("modular_exponentiation_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        // after reset: exponent 1, modulus 2
        directed_steps.push_back(typed_step('0, '0));
        directed_steps.push_back(typed_step(FIELD_MAX, EXP_W'(1)));
        directed_steps.push_back(typed_step(EXP_W'(6), '0));
        // zero exponent
        directed_steps.push_back(cfg_step(CFG_EXPONENT, '0));
        directed_steps.push_back(typed_step('0, EXP_W'(1)));
        directed_steps.push_back(typed_step(FIELD_MAX, EXP_W'(1)));
        // widest key: (-1)^odd stays -1, base equal to modulus gives 0
        directed_steps.push_back(cfg_step(CFG_MODULUS, FIELD_MAX));
        directed_steps.push_back(cfg_step(CFG_EXPONENT, FIELD_MAX));
        directed_steps.push_back(typed_step(FIELD_MAX - EXP_W'(1), FIELD_MAX - EXP_W'(1)));
        directed_steps.push_back(typed_step(FIELD_MAX, '0));
        directed_steps.push_back(base_step(EXP_W'(2)));
        directed_steps.push_back(base_step(EXP_W'(32'h1234_5678)));
        // modulus of one, with and without a zero exponent
        directed_steps.push_back(cfg_step(CFG_MODULUS, EXP_W'(1)));
        directed_steps.push_back(typed_step(EXP_W'(5), '0));
        directed_steps.push_back(cfg_step(CFG_EXPONENT, '0));
        directed_steps.push_back(typed_step(EXP_W'(3), '0));
        // modulus of zero
        directed_steps.push_back(cfg_step(CFG_MODULUS, '0));
        directed_steps.push_back(typed_step(EXP_W'(9), '0));
        directed_steps.push_back(typed_step(FIELD_MAX, '0));
        // spare indexes must leave the key alone
        directed_steps.push_back(cfg_step(REG_SPARE_A, EXP_W'(32'h5555_5555)));
        directed_steps.push_back(cfg_step(REG_SPARE_B, EXP_W'(32'h2AAA_AAAA)));
        directed_steps.push_back(typed_step(EXP_W'(4), '0));
        // typical public key
        directed_steps.push_back(cfg_step(CFG_MODULUS, EXP_W'(1000003)));
        directed_steps.push_back(cfg_step(CFG_EXPONENT, EXP_W'(65537)));
        directed_steps.push_back(base_step(EXP_W'(2)));
        directed_steps.push_back(base_step(EXP_W'(1000003 + 5)));
        directed_steps.push_back(base_step(EXP_W'(1000002)));
        directed_steps.push_back(cfg_step(CFG_MODULUS, EXP_W'(3)));
        directed_steps.push_back(cfg_step(CFG_EXPONENT, EXP_W'(2)));
        directed_steps.push_back(typed_step(EXP_W'(2), EXP_W'(1)));
        // top exponent bit alone
        directed_steps.push_back(cfg_step(CFG_EXPONENT, EXP_W'(32'h4000_0000)));
        directed_steps.push_back(cfg_step(CFG_MODULUS, EXP_W'(32'h4000_0001)));
        directed_steps.push_back(base_step(EXP_W'(3)));
        directed_steps.push_back(base_step(FIELD_MAX));
        // alternating bit patterns
        directed_steps.push_back(cfg_step(CFG_EXPONENT, EXP_W'(32'h2AAA_AAAA)));
        directed_steps.push_back(cfg_step(CFG_MODULUS, EXP_W'(32'h5555_5555)));
        directed_steps.push_back(base_step(EXP_W'(32'h2AAA_AAAA)));
        directed_steps.push_back(base_step(EXP_W'(32'h5555_5555)));

        send_idle_pct = 32;
        recv_idle_pct = 82;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE)
                write_register(directed_steps[i].index, directed_steps[i].value);
            else
                send_base(directed_steps[i].value, directed_steps[i].typed,
                          directed_steps[i].want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 32; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                write_register(CFG_EXPONENT, pick_exponent());
                write_register(CFG_MODULUS, pick_modulus());
                if ($urandom_range(3) == 0)
                    write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                                   EXP_W'($urandom));
                n_settings++;
                for (int k = 0; k < BASES_PER_SETTING; k++)
                    send_base(pick_base(key_modulus), 1'b0, '0);
            end
        end

        // hold the last request no longer, then let the block drain
        i_in_valid <= 1'b0;
        while (residues_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        n_failures += residues_due.size();

        $display("%0d requests, %0d results, %0d register writes, %0d random key settings",
                 n_requests, n_results, n_writes, n_settings);
        $display("keys included zero and full-width exponents, moduli 0, 1, 2 and max");
        if (n_failures == 0)
            $display("modular_exponentiation_test OK");
        else
            $display("modular_exponentiation_test NOT OK");
        $finish;
    end

endmodule

/* modular_exponentiation.f */
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_seq.sv
rtl/modular_exponentiation.sv
dv/modular_exponentiation_test.sv
